FILE: rtl/chacha20_stream_xor_top_macros.svh
// ----------------------------------------------------------------------------
// ChaCha20 stream XOR assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the asynchronous active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef CHACHA20_STREAM_XOR_TOP_MACROS_SVH
`define CHACHA20_STREAM_XOR_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CC20_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CC20_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/cc20_pkg.sv
// ----------------------------------------------------------------------------
// ChaCha20 stream XOR package
// Types, constants and widths shared by the keystream XOR block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cc20_pkg;

    localparam int BLOCK_BYTES  = 64;
    localparam int BUF_ROWS     = BLOCK_BYTES / 16;
    localparam int BUF_ROW_W    = $clog2(BUF_ROWS);
    localparam int POS_W        = $clog2(BLOCK_BYTES) + 1;
    localparam int ROUND_CYCLES = 10 * 2 * 4;
    localparam int RND_CNT_W    = $clog2(ROUND_CYCLES);
    localparam int CFG_ADDR_W   = 6;
    localparam int CFG_DATA_W   = 64;

    typedef logic [31:0]      word_t;
    typedef word_t [3:0]      row_t;
    typedef row_t [3:0]       blk_t;

    localparam word_t SIGMA_0 = 32'h61707865;
    localparam word_t SIGMA_1 = 32'h3320646e;
    localparam word_t SIGMA_2 = 32'h79622d32;
    localparam word_t SIGMA_3 = 32'h6b206574;

    // rotate amount, indexed by the step within a quarter round
    typedef enum logic [1:0] {
        ROT_16,
        ROT_12,
        ROT_8,
        ROT_7
    } rot_e;

    typedef struct packed {
        logic [63:0] key_01;
        logic [63:0] key_23;
        logic [63:0] key_45;
        logic [63:0] key_67;
        logic [63:0] nonce_lo;
        word_t       nonce_hi;
        word_t       start_ctr;
    } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/cc20_in_if.sv
// ----------------------------------------------------------------------------
// ChaCha20 input channel
// Valid/ready channel that carries one data byte request and its flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cc20_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       restart;
    logic       call_last;

    modport source (output valid, output data_byte, output restart, output call_last,
                    input ready);
    modport sink   (input valid, input data_byte, input restart, input call_last,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/cc20_out_if.sv
// ----------------------------------------------------------------------------
// ChaCha20 output channel
// Valid/ready channel that carries one transformed byte and its last flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cc20_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

FILE: rtl/chacha20_stream_xor_top.sv
// ----------------------------------------------------------------------------
// ChaCha20 stream XOR top level
// Timing: a request that finds bytes in the keystream buffer goes from
//   S_IDLE through S_XOR into the result register; when a new block is needed,
//   it first passes 80 round steps on the shared ARX unit, 4 feed-forward rows, 1 read.
// Flow: requests are taken only in S_IDLE, after the last has left S_XOR; refill per 64 bytes or restart.
// Reset: state loads constants and zero key/nonce/counter, buffer marked empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module chacha20_stream_xor_top
    import cc20_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    cc20_in_if.sink                    din,
    cc20_out_if.source                 dout,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready
);

    `include "chacha20_stream_xor_top_macros.svh"

    // Sequencer states:
    //   S_IDLE  - take a request; load the working block if a refill follows
    //   S_ROUND - 80 ARX steps: 10 double rounds x 2 half rounds x 4 steps
    //   S_FIN   - feed-forward add, one 4-word row per cycle into the buffer
    //   S_READ  - let the registered buffer read catch up with position 0
    //   S_XOR   - combine data with keystream byte, hold until output is free
    typedef enum logic [2:0] {
        S_IDLE,
        S_ROUND,
        S_FIN,
        S_READ,
        S_XOR
    } state_e;

    localparam logic [RND_CNT_W-1:0] RND_LAST = RND_CNT_W'(ROUND_CYCLES - 1);

    state_e                 state_reg;
    logic [RND_CNT_W-1:0]   rnd_cnt_reg;
    logic [BUF_ROW_W-1:0]   fin_cnt_reg;
    logic [POS_W-1:0]       pos_reg;
    blk_t                   blk_reg;
    blk_t                   w_reg;
    blk_t                   w_next;
    logic [7:0]             data_reg;
    logic                   last_reg;
    logic                   out_valid_reg;
    logic [7:0]             out_byte_reg;
    logic                   out_last_reg;

    cfg_t                   cfg;
    blk_t                   cfg_blk;
    logic                   in_fire;
    logic                   out_free;
    logic [1:0]             step;
    logic                   diag_half;
    rot_e                   rot;
    row_t                   p_row;
    row_t                   q_row;
    row_t                   t_row;
    row_t                   sum_row;
    row_t                   mix_row;
    logic [7:0]             ks_byte;
    word_t                  ctr_inc;

    // Map the register set onto the 16-word block layout.
    function automatic blk_t cfg_block(input cfg_t c);
        blk_t b;
        b[0][0] = SIGMA_0;
        b[0][1] = SIGMA_1;
        b[0][2] = SIGMA_2;
        b[0][3] = SIGMA_3;
        b[1][0] = c.key_01[31:0];
        b[1][1] = c.key_01[63:32];
        b[1][2] = c.key_23[31:0];
        b[1][3] = c.key_23[63:32];
        b[2][0] = c.key_45[31:0];
        b[2][1] = c.key_45[63:32];
        b[2][2] = c.key_67[31:0];
        b[2][3] = c.key_67[63:32];
        b[3][0] = c.start_ctr;
        b[3][1] = c.nonce_lo[31:0];
        b[3][2] = c.nonce_lo[63:32];
        b[3][3] = c.nonce_hi;
        return b;
    endfunction

    cc20_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign cfg_blk   = cfg_block(cfg);
    assign din.ready = (state_reg == S_IDLE);
    assign in_fire   = din.valid && din.ready;
    assign out_free  = !out_valid_reg || dout.ready;

    assign dout.valid    = out_valid_reg;
    assign dout.out_byte = out_byte_reg;
    assign dout.out_last = out_last_reg;

    // Round step decode: step within the quarter round, and which half.
    assign step      = rnd_cnt_reg[1:0];
    assign diag_half = rnd_cnt_reg[2];
    assign rot       = rot_e'(step);

    // Rows are A=0, B=1, C=2, D=3. The diagonal half round works on rows
    // that were rotated at the end of the column half, so every lane of the
    // ARX unit always sees the same row positions.
    //   even step: A += B, D = rotl(D ^ A)
    //   odd step:  C += D, B = rotl(B ^ C)
    always_comb
    begin
        if (state_reg == S_FIN)
        begin
            p_row = w_reg[fin_cnt_reg];
            q_row = blk_reg[fin_cnt_reg];
            t_row = w_reg[fin_cnt_reg];
        end
        else if (step[0])
        begin
            p_row = w_reg[2];
            q_row = w_reg[3];
            t_row = w_reg[1];
        end
        else
        begin
            p_row = w_reg[0];
            q_row = w_reg[1];
            t_row = w_reg[3];
        end
    end

    cc20_arx_unit u_arx (
        .rot     (rot),
        .p_row   (p_row),
        .q_row   (q_row),
        .t_row   (t_row),
        .sum_row (sum_row),
        .mix_row (mix_row)
    );

    // Working block write-back. On the last step of a half round, rotate
    // rows B, C, D by 1, 2, 3 lanes into diagonal order, or back again.
    always_comb
    begin
        w_next = w_reg;
        if (step[0])
        begin
            w_next[2] = sum_row;
            w_next[1] = mix_row;
        end
        else
        begin
            w_next[0] = sum_row;
            w_next[3] = mix_row;
        end
        if (step == 2'd3)
        begin
            for (int j = 0; j < 4; j++)
            begin
                if (!diag_half)
                begin
                    w_next[1][j] = mix_row[2'(j + 1)];
                    w_next[2][j] = sum_row[2'(j + 2)];
                    w_next[3][j] = w_reg[3][2'(j + 3)];
                end
                else
                begin
                    w_next[1][j] = mix_row[2'(j + 3)];
                    w_next[2][j] = sum_row[2'(j + 2)];
                    w_next[3][j] = w_reg[3][2'(j + 1)];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            w_reg <= din.restart ? cfg_blk : blk_reg;
        end
        else if (state_reg == S_ROUND)
        begin
            w_reg <= w_next;
        end
    end

    // Buffer rows are written during feed-forward and read at the current
    // position every cycle; the position holds steady for the cycle after.
    cc20_ks_buf u_buf (
        .clk      (clk),
        .we       (state_reg == S_FIN),
        .waddr    (fin_cnt_reg),
        .wdata    (sum_row),
        .raddr    (pos_reg[5:4]),
        .byte_sel (pos_reg[3:0]),
        .ks_byte  (ks_byte)
    );

    // Block counter with carry into the first nonce word.
    assign ctr_inc = blk_reg[3][0] + 32'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rnd_cnt_reg   <= '0;
            fin_cnt_reg   <= '0;
            pos_reg       <= POS_W'(BLOCK_BYTES);
            blk_reg       <= cfg_block('0);
            data_reg      <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            // drop the result once the sink takes it; the XOR stage
            // reloads the output register on its own
            if (out_valid_reg && dout.ready && state_reg != S_XOR)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        data_reg <= din.data_byte;
                        last_reg <= din.call_last;
                        if (din.restart)
                        begin
                            blk_reg <= cfg_blk;
                            pos_reg <= POS_W'(BLOCK_BYTES);
                        end
                        if (din.restart || pos_reg[POS_W-1])
                        begin
                            rnd_cnt_reg <= '0;
                            state_reg   <= S_ROUND;
                        end
                        else
                        begin
                            state_reg <= S_XOR;
                        end
                    end
                end

                S_ROUND:
                begin
                    rnd_cnt_reg <= rnd_cnt_reg + RND_CNT_W'(1);
                    if (rnd_cnt_reg == RND_LAST)
                    begin
                        fin_cnt_reg <= '0;
                        state_reg   <= S_FIN;
                    end
                end

                S_FIN:
                begin
                    fin_cnt_reg <= fin_cnt_reg + BUF_ROW_W'(1);
                    if (fin_cnt_reg == BUF_ROW_W'(BUF_ROWS - 1))
                    begin
                        // advance the block counter, restart at byte 0
                        blk_reg[3][0] <= ctr_inc;
                        if (ctr_inc == '0)
                        begin
                            blk_reg[3][1] <= blk_reg[3][1] + 32'd1;
                        end
                        pos_reg   <= '0;
                        state_reg <= S_READ;
                    end
                end

                S_READ:
                begin
                    state_reg <= S_XOR;
                end

                S_XOR:
                begin
                    // hold until the output register is free
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_byte_reg  <= data_reg ^ ks_byte;
                        out_last_reg  <= last_reg;
                        pos_reg       <= pos_reg + POS_W'(1);
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // A request that needs no refill goes straight to the XOR stage.
    `CC20_ASSERT_NEXT(a_fast_path, clk, rst_n, in_fire && !din.restart && !pos_reg[POS_W-1], state_reg == S_XOR, "byte with buffered keystream did not go to XOR")

    // The XOR stage only ever reads a position inside the buffer.
    `CC20_ASSERT_SAME(a_pos_in_range, clk, rst_n, state_reg == S_XOR, !pos_reg[POS_W-1], "keystream read past end of buffer")

    // The last round step hands over to the first feed-forward row.
    `CC20_ASSERT_NEXT(a_round_done, clk, rst_n, state_reg == S_ROUND && rnd_cnt_reg == RND_LAST, state_reg == S_FIN && fin_cnt_reg == '0, "round sequence did not end in feed-forward")

    // Finishing a block rewinds the position to the first byte.
    `CC20_ASSERT_NEXT(a_block_rewind, clk, rst_n, state_reg == S_FIN && fin_cnt_reg == BUF_ROW_W'(BUF_ROWS - 1), state_reg == S_READ && pos_reg == '0, "new block did not rewind byte position")

endmodule

`default_nettype wire

FILE: rtl/cc20_cfg_regs.sv
// ----------------------------------------------------------------------------
// ChaCha20 configuration registers
// APB-style register file for key, nonce and start counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cc20_cfg_regs
    import cc20_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    localparam logic [2:0] REG_KEY_01    = 3'd0;
    localparam logic [2:0] REG_KEY_23    = 3'd1;
    localparam logic [2:0] REG_KEY_45    = 3'd2;
    localparam logic [2:0] REG_KEY_67    = 3'd3;
    localparam logic [2:0] REG_NONCE_LO  = 3'd4;
    localparam logic [2:0] REG_NONCE_HI  = 3'd5;
    localparam logic [2:0] REG_START_CTR = 3'd6;

    cfg_t       cfg_reg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[CFG_ADDR_W-1:3];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_KEY_01:    cfg_reg.key_01    <= pwdata;
                REG_KEY_23:    cfg_reg.key_23    <= pwdata;
                REG_KEY_45:    cfg_reg.key_45    <= pwdata;
                REG_KEY_67:    cfg_reg.key_67    <= pwdata;
                REG_NONCE_LO:  cfg_reg.nonce_lo  <= pwdata;
                REG_NONCE_HI:  cfg_reg.nonce_hi  <= pwdata[31:0];
                REG_START_CTR: cfg_reg.start_ctr <= pwdata[31:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_KEY_01:    prdata = cfg_reg.key_01;
            REG_KEY_23:    prdata = cfg_reg.key_23;
            REG_KEY_45:    prdata = cfg_reg.key_45;
            REG_KEY_67:    prdata = cfg_reg.key_67;
            REG_NONCE_LO:  prdata = cfg_reg.nonce_lo;
            REG_NONCE_HI:  prdata = {32'd0, cfg_reg.nonce_hi};
            REG_START_CTR: prdata = {32'd0, cfg_reg.start_ctr};
            default:       prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/cc20_arx_unit.sv
// ----------------------------------------------------------------------------
// ChaCha20 ARX unit
// Four-lane add, XOR and rotate step, shared by all round steps and by
// the final feed-forward add.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cc20_arx_unit
    import cc20_pkg::*;
(
    input  wire rot_e rot,
    input  wire row_t p_row,
    input  wire row_t q_row,
    input  wire row_t t_row,
    output row_t      sum_row,
    output row_t      mix_row
);

    always_comb
    begin
        word_t x;
        for (int j = 0; j < 4; j++)
        begin
            sum_row[j] = p_row[j] + q_row[j];
            x          = t_row[j] ^ sum_row[j];
            unique case (rot)
                ROT_16: mix_row[j] = {x[15:0], x[31:16]};
                ROT_12: mix_row[j] = {x[19:0], x[31:20]};
                ROT_8:  mix_row[j] = {x[23:0], x[31:24]};
                ROT_7:  mix_row[j] = {x[24:0], x[31:25]};
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/cc20_ks_buf.sv
// ----------------------------------------------------------------------------
// ChaCha20 keystream buffer
// 64-byte keystream memory, one 16-byte row written per cycle, registered
// row read and byte select.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cc20_ks_buf
    import cc20_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [BUF_ROW_W-1:0] waddr,
    input  wire row_t                 wdata,
    input  wire logic [BUF_ROW_W-1:0] raddr,
    input  wire logic [3:0]           byte_sel,
    output logic      [7:0]           ks_byte
);

    row_t             mem [BUF_ROWS];
    logic [15:0][7:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    // byte 4*i+k of a row is byte k of word i, little-endian
    assign ks_byte = rd_reg[byte_sel];

endmodule

`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ChaCha20 stream XOR testbench
// Streams byte requests through the keystream XOR block and checks every
// transformed byte against a predictor kept inside this bench. The predictor
// holds its own block state, keystream buffer and register copy. Registers
// are programmed over the APB port between phases, while nothing is in flight.
// The sender runs in bursts with random gaps. The receiver stalls on patterns
// of its own, and twice holds off long enough to back the block up.
// ----------------------------------------------------------------------------

module tb
    import cc20_pkg::*;
();

    // Cycles with no accepted request, result or register write before the
    // run is declared hung. The slowest legal stretch is a receiver hold-off
    // plus one block refill, so this is ample.
    localparam int WATCHDOG_LIMIT = 5000;
    // Drain time after the last result, for any stray result to show.
    localparam int TAIL_CYCLES    = 100;
    localparam int SETTLE_CYCLES  = 4;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_REQUESTS = 50;

    // Register slots on the configuration port, 8 bytes apart.
    typedef enum logic [2:0] {
        REG_KEY_01,
        REG_KEY_23,
        REG_KEY_45,
        REG_KEY_67,
        REG_NONCE_LO,
        REG_NONCE_HI,
        REG_START_CTR,
        REG_UNUSED
    } cfg_reg_e;

    // Receiver stall patterns.
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_PERIODIC,
        RX_COIN,
        RX_SPARSE
    } rx_mode_e;

    typedef struct packed {
        logic [7:0] data;
        logic       restart;
        logic       last;
    } xor_req_t;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } cipher_byte_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    cc20_in_if  req_ch ();
    cc20_out_if res_ch ();

    chacha20_stream_xor_top uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .din     (req_ch),
        .dout    (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: register copy, block state, keystream buffer
    // ------------------------------------------------------------------
    cfg_t       cfg_shadow;
    word_t      ks_state [16];
    word_t      mix_w [16];
    logic [7:0] ks_buf [BLOCK_BYTES];
    logic [6:0] ks_pos;

    xor_req_t     pending_requests [$];
    cipher_byte_t expected_out [$];

    int in_offered      = 0;
    int in_accepted     = 0;
    int results_seen    = 0;
    int errors          = 0;
    int blocks_made     = 0;
    int counter_carries = 0;
    int restarts_seen   = 0;
    int messages        = 0;
    int settings_loaded = 0;

    function automatic word_t rotl32(word_t v, int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic void quarter_round(int a, int b, int c, int d);
        mix_w[a] = mix_w[a] + mix_w[b]; mix_w[d] = rotl32(mix_w[d] ^ mix_w[a], 16);
        mix_w[c] = mix_w[c] + mix_w[d]; mix_w[b] = rotl32(mix_w[b] ^ mix_w[c], 12);
        mix_w[a] = mix_w[a] + mix_w[b]; mix_w[d] = rotl32(mix_w[d] ^ mix_w[a], 8);
        mix_w[c] = mix_w[c] + mix_w[d]; mix_w[b] = rotl32(mix_w[b] ^ mix_w[c], 7);
    endfunction

    // Load the block state from the register copy and mark the buffer empty.
    function automatic void reload_state();
        ks_state[0]  = SIGMA_0;
        ks_state[1]  = SIGMA_1;
        ks_state[2]  = SIGMA_2;
        ks_state[3]  = SIGMA_3;
        ks_state[4]  = cfg_shadow.key_01[31:0];
        ks_state[5]  = cfg_shadow.key_01[63:32];
        ks_state[6]  = cfg_shadow.key_23[31:0];
        ks_state[7]  = cfg_shadow.key_23[63:32];
        ks_state[8]  = cfg_shadow.key_45[31:0];
        ks_state[9]  = cfg_shadow.key_45[63:32];
        ks_state[10] = cfg_shadow.key_67[31:0];
        ks_state[11] = cfg_shadow.key_67[63:32];
        ks_state[12] = cfg_shadow.start_ctr;
        ks_state[13] = cfg_shadow.nonce_lo[31:0];
        ks_state[14] = cfg_shadow.nonce_lo[63:32];
        ks_state[15] = cfg_shadow.nonce_hi;
        ks_pos       = 7'(BLOCK_BYTES);
    endfunction

    // Run the 20 rounds, add the state back, store little-endian, then
    // advance the counter with its carry into word 13.
    function automatic void refill_keystream();
        int    i;
        int    r;
        word_t sum;
        for (i = 0; i < 16; i++)
            mix_w[i] = ks_state[i];
        for (r = 0; r < 10; r++)
        begin
            quarter_round(0, 4, 8, 12);
            quarter_round(1, 5, 9, 13);
            quarter_round(2, 6, 10, 14);
            quarter_round(3, 7, 11, 15);
            quarter_round(0, 5, 10, 15);
            quarter_round(1, 6, 11, 12);
            quarter_round(2, 7, 8, 13);
            quarter_round(3, 4, 9, 14);
        end
        for (i = 0; i < 16; i++)
        begin
            sum             = mix_w[i] + ks_state[i];
            ks_buf[4*i]     = sum[7:0];
            ks_buf[4*i + 1] = sum[15:8];
            ks_buf[4*i + 2] = sum[23:16];
            ks_buf[4*i + 3] = sum[31:24];
        end
        ks_state[12] = ks_state[12] + 32'd1;
        if (ks_state[12] == 32'd0)
        begin
            ks_state[13] = ks_state[13] + 32'd1;
            counter_carries++;
        end
        ks_pos = 7'd0;
        blocks_made++;
    endfunction

    function automatic cipher_byte_t predict_byte(logic [7:0] data, logic restart,
                                                  logic last);
        cipher_byte_t r;
        if (restart)
        begin
            reload_state();
            restarts_seen++;
        end
        if (ks_pos >= BLOCK_BYTES)
            refill_keystream();
        r.value = data ^ ks_buf[ks_pos[5:0]];
        r.last  = last;
        ks_pos  = ks_pos + 7'd1;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request driver: pop the next request once the current one is taken,
    // work in bursts with random gaps between them.
    // ------------------------------------------------------------------
    xor_req_t next_req;
    int       burst_left = 8;
    int       gap_left   = 0;

    always @(negedge clk)
    begin
        // The slot is free when nothing is offered or the offered request
        // was accepted at the last rising edge.
        if (!req_ch.valid || in_accepted == in_offered)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                req_ch.valid <= 1'b0;
            end
            else if (pending_requests.size() != 0)
            begin
                next_req = pending_requests.pop_front();
                req_ch.valid     <= 1'b1;
                req_ch.data_byte <= next_req.data;
                req_ch.restart   <= next_req.restart;
                req_ch.call_last <= next_req.last;
                in_offered++;
                if (burst_left <= 1)
                begin
                    // Roughly a third of bursts run straight into the next one.
                    burst_left = $urandom_range(1, 48);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
                else
                begin
                    burst_left--;
                end
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: stall on a pattern that is redrawn at random, and hold
    // off twice for a long stretch so the block backs up.
    // ------------------------------------------------------------------
    rx_mode_e rx_mode    = RX_OPEN;
    int       rx_cycle   = 0;
    int       hold_left  = 0;
    int       holds_done = 0;

    always @(negedge clk)
    begin
        rx_cycle++;
        if (hold_left == 0 && ((holds_done == 0 && results_seen >= 120) ||
                               (holds_done == 1 && results_seen >= 330)))
        begin
            hold_left = HOLD_CYCLES;
            holds_done++;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (rx_cycle % 48 == 0)
                rx_mode = rx_mode_e'($urandom_range(0, 3));
            case (rx_mode)
                RX_OPEN:     res_ch.ready <= 1'b1;
                RX_PERIODIC: res_ch.ready <= (rx_cycle % 3) != 0;
                RX_COIN:     res_ch.ready <= 1'($urandom_range(0, 1));
                default:     res_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on every accepted request, check every accepted
    // result against the oldest prediction.
    // ------------------------------------------------------------------
    cipher_byte_t want;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                expected_out.push_back(predict_byte(req_ch.data_byte, req_ch.restart,
                                                    req_ch.call_last));
                in_accepted++;
            end
            if (res_ch.valid && res_ch.ready)
            begin
                results_seen++;
                if (expected_out.size() == 0)
                begin
                    $display("%0t: result with nothing expected, actual byte %02h last %0b",
                             $time, res_ch.out_byte, res_ch.out_last);
                    errors++;
                end
                else
                begin
                    want = expected_out.pop_front();
                    if (res_ch.out_byte !== want.value)
                    begin
                        $display("%0t: out_byte of result %0d, expected %02h, actual %02h",
                                 $time, results_seen, want.value, res_ch.out_byte);
                        errors++;
                    end
                    if (res_ch.out_last !== want.last)
                    begin
                        $display("%0t: out_last of result %0d, expected %0b, actual %0b",
                                 $time, results_seen, want.last, res_ch.out_last);
                        errors++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run when nothing moves for too long.
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (psel && penable && pready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles, %0d results still expected",
                         $time, idle_cycles, expected_out.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_request(input logic [7:0] data, input logic restart,
                                 input logic last);
        xor_req_t r;
        r.data    = data;
        r.restart = restart;
        r.last    = last;
        pending_requests.push_back(r);
    endtask

    // Setup cycle, then access cycle; the write lands at the edge where
    // pready is seen high during the access cycle.
    task automatic apb_write(input cfg_reg_e idx, input logic [63:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_KEY_01:    cfg_shadow.key_01    = value;
            REG_KEY_23:    cfg_shadow.key_23    = value;
            REG_KEY_45:    cfg_shadow.key_45    = value;
            REG_KEY_67:    cfg_shadow.key_67    = value;
            REG_NONCE_LO:  cfg_shadow.nonce_lo  = value;
            REG_NONCE_HI:  cfg_shadow.nonce_hi  = value[31:0];
            REG_START_CTR: cfg_shadow.start_ctr = value[31:0];
            default:       ;
        endcase
    endtask

    // Hold until nothing is queued, offered or expected. Sampled at the
    // rising edge, where the driven valid is stable.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_requests.size() != 0 || req_ch.valid || expected_out.size() != 0);
    endtask

    // Drain, then program every register; the unused slot gets junk that
    // must be dropped. Return on a rising edge so the next pushes do not
    // meet the driver in the same step.
    task automatic start_phase(input cfg_t s);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        apb_write(REG_KEY_01, s.key_01);
        apb_write(REG_KEY_23, s.key_23);
        apb_write(REG_KEY_45, s.key_45);
        apb_write(REG_KEY_67, s.key_67);
        apb_write(REG_NONCE_LO, s.nonce_lo);
        apb_write(REG_NONCE_HI, {32'hFFFF_FFFF, s.nonce_hi});
        apb_write(REG_START_CTR, {$urandom, s.start_ctr});
        apb_write(REG_UNUSED, {$urandom, $urandom});
        settings_loaded++;
        @(posedge clk);
    endtask

    function automatic cfg_t random_settings();
        cfg_t s;
        s.key_01    = {$urandom, $urandom};
        s.key_23    = {$urandom, $urandom};
        s.key_45    = {$urandom, $urandom};
        s.key_67    = {$urandom, $urandom};
        s.nonce_lo  = {$urandom, $urandom};
        s.nonce_hi  = $urandom;
        s.start_ctr = $urandom;
        return s;
    endfunction

    // Mostly whole messages: restart on the first byte, call_last on the
    // final one. Some run past a block or two. The rest are loose bytes
    // with random flags, continuing or breaking the stream.
    task automatic queue_random_traffic(input int target);
        int queued;
        int len;
        int k;
        queued = 0;
        while (queued < target)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 40)
                                                 : $urandom_range(65, 160);
                for (k = 0; k < len; k++)
                    queue_request(8'($urandom_range(0, 255)), k == 0, k == len - 1);
                queued += len;
                messages++;
            end
            else
            begin
                queue_request(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0,
                              1'($urandom_range(0, 1)));
                queued++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    cfg_t settings;

    initial
    begin
        // Drive every input to a known value before the first edge.
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        req_ch.valid     = 1'b0;
        req_ch.data_byte = 8'h00;
        req_ch.restart   = 1'b0;
        req_ch.call_last = 1'b0;
        res_ch.ready     = 1'b0;

        cfg_shadow = '0;
        reload_state();

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: zero key, nonce and counter. The first byte must
        // start a block on its own, with no restart.
        queue_request(8'h00, 1'b0, 1'b0);
        queue_request(8'hFF, 1'b0, 1'b1);
        queue_request(8'h80, 1'b0, 1'b0);
        queue_request(8'h01, 1'b0, 1'b1);
        // Restart in the middle of a block: reload, then a fresh block.
        queue_request(8'h7F, 1'b1, 1'b0);
        queue_request(8'hFE, 1'b0, 1'b1);

        // All-ones registers. The first two bytes still use the old state,
        // since a write only takes effect at the next restart.
        settings = '1;
        start_phase(settings);
        queue_request(8'h00, 1'b0, 1'b0);
        queue_request(8'h55, 1'b0, 1'b0);
        queue_request(8'hFF, 1'b1, 1'b0);
        queue_request(8'hAA, 1'b0, 1'b0);
        queue_request(8'h00, 1'b0, 1'b1);

        // Mixed extremes: zero key halves against all-ones halves, counter
        // at its top so the first refill wraps it.
        settings.key_01    = 64'h0000_0000_FFFF_FFFF;
        settings.key_23    = 64'hFFFF_FFFF_0000_0000;
        settings.key_45    = 64'h0;
        settings.key_67    = 64'hFFFF_FFFF_FFFF_FFFF;
        settings.nonce_lo  = 64'h0000_0000_FFFF_FFFF;
        settings.nonce_hi  = 32'h0;
        settings.start_ctr = 32'hFFFF_FFFF;
        start_phase(settings);
        // Restart and last on the same byte, then back-to-back restarts.
        queue_request(8'h3C, 1'b1, 1'b1);
        queue_request(8'hC3, 1'b1, 1'b0);
        queue_request(8'h0F, 1'b1, 1'b0);
        queue_request(8'hF0, 1'b0, 1'b0);
        queue_request(8'h00, 1'b0, 1'b1);
        queue_request(8'hFF, 1'b1, 1'b1);

        // Random traffic under several settings, extremes among them.
        start_phase(random_settings());
        queue_random_traffic(PHASE_REQUESTS);

        // All ones: counter and word 13 both wrap on the first refill.
        settings = '1;
        start_phase(settings);
        queue_random_traffic(PHASE_REQUESTS);

        // All zeros with the counter two short of the wrap.
        settings           = '0;
        settings.start_ctr = 32'hFFFF_FFFE;
        start_phase(settings);
        queue_random_traffic(PHASE_REQUESTS);

        settings           = random_settings();
        settings.start_ctr = 32'hFFFF_FFFF;
        start_phase(settings);
        queue_random_traffic(PHASE_REQUESTS);

        start_phase(random_settings());
        queue_random_traffic(PHASE_REQUESTS);

        // Drain, then give the block time enough for a refill, to show any
        // stray result.
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_out.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, expected_out.size());
            errors++;
        end

        $display("Covered %0d requests (%0d random messages, %0d restarts) under %0d settings.",
                 in_accepted, messages, restarts_seen, settings_loaded + 1);
        $display("Predicted %0d keystream blocks, %0d counter carries, %0d long hold-offs.",
                 blocks_made, counter_carries, holds_done);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
